>>> sv/liu_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the linear interpolation upsampler.
// Holds register layout, default sizes and the lane count; depends on nothing.
package liu_pkg;

   // Two lanes: the real (I) part and the imaginary (Q) part.
   localparam int NUM_LANES = 2;
   localparam int LANE_RE   = 0;
   localparam int LANE_IM   = 1;

   localparam int DEF_MAX_FACTOR  = 16;
   localparam int DEF_SAMPLE_BITS = 16;

   // Configuration register file.
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int FACTOR_REG_W = 5;
   localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = FACTOR_REG_W'(2);
   localparam logic REG_FACTOR = 1'b0;   // word index of the factor register

endpackage

>>> sv/liu_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle on both lanes at once.
// Depends on liu_pkg for the lane count and default widths.
module liu_div #(
   parameter int DIVIDEND_W = liu_pkg::DEF_SAMPLE_BITS + 1,
   parameter int DIVISOR_W  = liu_pkg::FACTOR_REG_W
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [liu_pkg::NUM_LANES-1:0][DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic done,
   output logic [liu_pkg::NUM_LANES-1:0][DIVIDEND_W-1:0] quotient,
   output logic [liu_pkg::NUM_LANES-1:0][DIVISOR_W-1:0] remainder
);
   import liu_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [NUM_LANES-1:0][DIVIDEND_W-1:0] num_ff, num_in;
   logic [NUM_LANES-1:0][DIVISOR_W-1:0] rem_ff, rem_in;
   logic [NUM_LANES-1:0][DIVISOR_W:0] rem_shift;
   logic [NUM_LANES-1:0][DIVISOR_W:0] rem_diff;
   logic [NUM_LANES-1:0] fits;

   // One restoring step per lane: shift in the next dividend bit and try a subtract.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         rem_shift[l] = {rem_ff[l], num_ff[l][DIVIDEND_W-1]};
         rem_diff[l]  = rem_shift[l] - {1'b0, divisor_ff};
         fits[l]      = rem_shift[l] >= {1'b0, divisor_ff};
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         divisor_in = divisor;
         num_in     = dividend;
         rem_in     = '0;
      end else if (busy_ff) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            rem_in[l] = fits[l] ? rem_diff[l][DIVISOR_W-1:0] : rem_shift[l][DIVISOR_W-1:0];
            num_in[l] = {num_ff[l][DIVIDEND_W-2:0], fits[l]};
         end
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      divisor_ff <= divisor_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/linear_interp_upsampler.sv
`timescale 1ns / 1ps
// Linear interpolation upsampler, top level. Uses liu_pkg and liu_div.
// An input that closes an interval starts the bit-serial divider as it is accepted;
// when the divider is done, the words follow one per cycle while the output register
// can take them. No new input is taken until all words of that input have been
// registered for output; a first sample that opens a block is only stored.
// Reset is synchronous and active high: factor 2, no stored sample, output empty.
module linear_interp_upsampler #(
   parameter int MAX_FACTOR  = liu_pkg::DEF_MAX_FACTOR,
   parameter int SAMPLE_BITS = liu_pkg::DEF_SAMPLE_BITS
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_real,
   input  logic signed [SAMPLE_BITS-1:0] req_in_imag,
   input  logic req_in_last,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_real,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_imag,
   output logic rsp_out_last,

   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [liu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [liu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [liu_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);
   import liu_pkg::*;

   // The difference of two samples needs one bit more than a sample. Its magnitude is
   // unsigned and fits in the same width, as does every accumulated quotient.
   localparam int DW = SAMPLE_BITS + 1;
   // Wide enough to hold the effective factor itself.
   localparam int FW = $clog2(MAX_FACTOR + 1);
   // Width in which the register value and the factor limit are compared.
   localparam int CW = (FW > FACTOR_REG_W) ? FW : FACTOR_REG_W;
   localparam logic [CW-1:0] MaxFactor = CW'(MAX_FACTOR);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_INTERP = 2'd2;
   localparam logic [1:0] ST_LAST   = 2'd3;

   // ---------------------------------------------------------------------------
   // Configuration register. Writes complete in the access phase; pready is tied
   // high so there are never wait states. Only the word index is decoded, so the
   // byte-offset bits of the address are ignored.
   // ---------------------------------------------------------------------------
   logic [FACTOR_REG_W-1:0] factor_ff, factor_in;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      factor_in = factor_ff;
      if (csr_write && (paddr[CSR_ADDR_W-1] == REG_FACTOR)) begin
         factor_in = pwdata[FACTOR_REG_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == REG_FACTOR) begin
         prdata = CSR_DATA_W'(factor_ff);
      end
   end

   // A factor of zero behaves as one, and anything above the limit saturates.
   logic [CW-1:0] factor_wide;
   logic [FW-1:0] factor_eff;

   always_comb begin
      factor_wide = CW'(factor_ff);
      if (factor_wide == '0) begin
         factor_eff = FW'(1);
      end else if (factor_wide > MaxFactor) begin
         factor_eff = FW'(MAX_FACTOR);
      end else begin
         factor_eff = factor_wide[FW-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer and sample store.
   // ---------------------------------------------------------------------------
   logic [1:0] state_ff, state_in;
   logic have_prev_ff, have_prev_in;
   logic signed [NUM_LANES-1:0][SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic signed [NUM_LANES-1:0][SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic last_ff, last_in;
   logic [FW-1:0] fe_ff, fe_in;
   logic [FW-1:0] step_ff, step_in;
   logic [NUM_LANES-1:0] neg_ff, neg_in;
   logic [NUM_LANES-1:0][DW-1:0] acc_q_ff, acc_q_in;
   logic [NUM_LANES-1:0][FW-1:0] acc_r_ff, acc_r_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_real_ff, rsp_real_in;
   logic signed [SAMPLE_BITS-1:0] rsp_imag_ff, rsp_imag_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic div_start;
   logic div_done;
   logic [NUM_LANES-1:0][DW-1:0] div_quot;
   logic [NUM_LANES-1:0][FW-1:0] div_rem;

   logic signed [NUM_LANES-1:0][SAMPLE_BITS-1:0] in_sample;
   logic signed [NUM_LANES-1:0][DW-1:0] diff;
   logic [NUM_LANES-1:0][DW-1:0] diff_mag;
   logic signed [NUM_LANES-1:0][DW:0] point;
   logic [NUM_LANES-1:0][FW:0] r_sum;
   logic [NUM_LANES-1:0][FW:0] r_wrap;
   logic [NUM_LANES-1:0] carry;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // The output register takes a new word when it is empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign in_sample[LANE_RE] = req_in_real;
   assign in_sample[LANE_IM] = req_in_imag;

   // The slope of each lane is split into sign and magnitude; the divider works on
   // magnitudes so that its quotient truncates toward zero once the sign is restored.
   // Both samples are sign-extended by one bit before the subtraction.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         diff[l]     = {in_sample[l][SAMPLE_BITS-1], in_sample[l]}
                     - {prev_ff[l][SAMPLE_BITS-1], prev_ff[l]};
         diff_mag[l] = diff[l][DW-1] ? (~diff[l] + 1'b1) : diff[l];
      end
   end

   // Point j is prev + sign * floor(j * |d| / f). The accumulators hold that floor as a
   // quotient and a remainder below f; each step adds |d| / f and |d| mod f, with one
   // compare and subtract to carry the remainder over.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         point[l]  = neg_ff[l] ? ((DW + 1)'(prev_ff[l]) - (DW + 1)'(acc_q_ff[l]))
                               : ((DW + 1)'(prev_ff[l]) + (DW + 1)'(acc_q_ff[l]));
         r_sum[l]  = {1'b0, acc_r_ff[l]} + {1'b0, div_rem[l]};
         carry[l]  = r_sum[l] >= {1'b0, fe_ff};
         r_wrap[l] = r_sum[l] - {1'b0, fe_ff};
      end
   end

   assign div_start = accept && have_prev_ff;

   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      fe_in        = fe_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      acc_q_in     = acc_q_ff;
      acc_r_in     = acc_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_real_in  = rsp_real_ff;
      rsp_imag_in  = rsp_imag_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in  = in_sample;
               last_in = req_in_last;
               fe_in   = factor_eff;
               for (int l = 0; l < NUM_LANES; l++) begin
                  neg_in[l] = diff[l][DW-1];
               end
               if (have_prev_ff) begin
                  state_in = ST_DIV;
               end else if (req_in_last) begin
                  // A lone last sample with no interval before it.
                  state_in = ST_LAST;
               end else begin
                  // First sample of a block: stored, nothing emitted.
                  prev_in      = in_sample;
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               acc_q_in = '0;
               acc_r_in = '0;
               step_in  = '0;
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_real_in  = point[LANE_RE][SAMPLE_BITS-1:0];
               rsp_imag_in  = point[LANE_IM][SAMPLE_BITS-1:0];
               rsp_last_in  = 1'b0;
               for (int l = 0; l < NUM_LANES; l++) begin
                  acc_q_in[l] = acc_q_ff[l] + div_quot[l] + DW'(carry[l]);
                  acc_r_in[l] = carry[l] ? r_wrap[l][FW-1:0] : r_sum[l][FW-1:0];
               end
               step_in = step_ff + 1'b1;
               if (step_ff == fe_ff - 1'b1) begin
                  if (last_ff) begin
                     state_in = ST_LAST;
                  end else begin
                     prev_in  = cur_ff;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_real_in  = cur_ff[LANE_RE];
               rsp_imag_in  = cur_ff[LANE_IM];
               rsp_last_in  = 1'b1;
               prev_in      = '0;
               have_prev_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_RESET;
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         factor_ff    <= factor_in;
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      fe_ff       <= fe_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      acc_q_ff    <= acc_q_in;
      acc_r_ff    <= acc_r_in;
      rsp_real_ff <= rsp_real_in;
      rsp_imag_ff <= rsp_imag_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Shared divider: slope magnitude over the effective factor, both lanes together.
   liu_div #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (FW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (diff_mag),
      .divisor   (factor_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_real = rsp_real_ff;
   assign rsp_out_imag = rsp_imag_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

>>> dv/tb_linear_interp_upsampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_upsampler: a directed part, then random
// sample streams under several factor settings. Depends on liu_pkg and the block's RTL.
module tb_linear_interp_upsampler;
   import liu_pkg::*;

   localparam int SW           = DEF_SAMPLE_BITS;
   localparam int MAX_FAC      = DEF_MAX_FACTOR;
   localparam int FACTOR_ADDR  = 4 * int'(REG_FACTOR);
   // The widest burst is MAX_FACTOR + 1 words; this many quiet cycles also covers the
   // divider, so it is enough for a word still in flight to appear.
   localparam int SETTLE       = SW + MAX_FAC + 16;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct packed {
      logic signed [SW-1:0] real_part;
      logic signed [SW-1:0] imag_part;
      logic                 is_last;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic signed [SW-1:0] req_in_real = '0;
   logic signed [SW-1:0] req_in_imag = '0;
   logic                 req_in_last = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic signed [SW-1:0] rsp_out_real;
   logic signed [SW-1:0] rsp_out_imag;
   logic                 rsp_out_last;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Our own copy of the block's state and its factor register.
   logic [FACTOR_REG_W-1:0] factor_reg = FACTOR_RESET;
   logic signed [SW-1:0]    held_real  = '0;
   logic signed [SW-1:0]    held_imag  = '0;
   logic                    held_valid = 1'b0;

   point_type expected_points[$];
   point_type front_point;

   int  err_count       = 0;
   int  samples_sent    = 0;
   int  words_checked   = 0;
   int  factor_settings = 0;
   int  cycle_count     = 0;
   // When set, neither side idles, so the block runs at its full rate.
   bit  steady_flow     = 1'b0;

   linear_interp_upsampler uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_real  (req_in_real),
      .req_in_imag  (req_in_imag),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_real (rsp_out_real),
      .rsp_out_imag (rsp_out_imag),
      .rsp_out_last (rsp_out_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake must not leave the run spinning for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // The receiver stalls in about 16 percent of cycles, unless steady flow is on.
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 16);
   end

   // Every word taken from the result channel is matched against the oldest
   // expectation. Values are sampled as they stood just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("Unexpected word: real %0d imag %0d last %0b",
                   rsp_out_real, rsp_out_imag, rsp_out_last);
            err_count++;
         end else begin
            front_point = expected_points.pop_front();
            words_checked++;
            if (rsp_out_real !== front_point.real_part) begin
               $error("out_real: expected %0d, actual %0d", front_point.real_part,
                      rsp_out_real);
               err_count++;
            end
            if (rsp_out_imag !== front_point.imag_part) begin
               $error("out_imag: expected %0d, actual %0d", front_point.imag_part,
                      rsp_out_imag);
               err_count++;
            end
            if (rsp_out_last !== front_point.is_last) begin
               $error("out_last: expected %0b, actual %0b", front_point.is_last,
                      rsp_out_last);
               err_count++;
            end
         end
      end
   end

   // The factor actually used: zero counts as one, and anything above the
   // maximum is held at the maximum.
   function automatic int effective_span(input logic [FACTOR_REG_W-1:0] reg_value);
      if (reg_value == 0) return 1;
      if (reg_value > MAX_FAC) return MAX_FAC;
      return int'(reg_value);
   endfunction

   // One point on the line from a to b. Integer division in SystemVerilog
   // truncates toward zero, which is what the block must do as well.
   function automatic logic signed [SW-1:0] line_point(input longint a, input longint b,
                                                       input longint step,
                                                       input longint span);
      longint v;
      v = a + (step * (b - a)) / span;
      return v[SW-1:0];
   endfunction

   // Works out the words that one accepted sample causes and queues them.
   task automatic interpolate_sample(input logic signed [SW-1:0] cur_real,
                                     input logic signed [SW-1:0] cur_imag,
                                     input logic cur_last);
      int        span;
      point_type p;
      if (held_valid) begin
         span = effective_span(factor_reg);
         for (int step = 0; step < span; step++) begin
            p.real_part = line_point(held_real, cur_real, step, span);
            p.imag_part = line_point(held_imag, cur_imag, step, span);
            p.is_last   = 1'b0;
            expected_points.push_back(p);
         end
      end
      if (cur_last) begin
         // The closing sample goes out once more on its own, then the block forgets it.
         p.real_part = cur_real;
         p.imag_part = cur_imag;
         p.is_last   = 1'b1;
         expected_points.push_back(p);
         held_real  = '0;
         held_imag  = '0;
         held_valid = 1'b0;
      end else begin
         held_real  = cur_real;
         held_imag  = cur_imag;
         held_valid = 1'b1;
      end
   endtask

   // Idle cycles before the next word: none most of the time, a short gap otherwise.
   function automatic int pick_gap();
      if (steady_flow || $urandom_range(0, 99) >= 16) return 0;
      return $urandom_range(1, 4);
   endfunction

   // Sample values lean towards full scale and towards zero, where the
   // arithmetic is most likely to go wrong.
   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(SW-1){1'b0}}};
         1: return {1'b0, {(SW-1){1'b1}}};
         2: return SW'(int'($urandom_range(0, 16)) - 8);
         default: return SW'($urandom());
      endcase
   endfunction

   // Offers one sample and holds it until the block takes it. The task starts and
   // ends just after a rising edge, so a back-to-back word is set up in one step.
   task automatic send_sample(input logic signed [SW-1:0] s_real,
                              input logic signed [SW-1:0] s_imag,
                              input logic s_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_real <= s_real;
      req_in_imag <= s_imag;
      req_in_last <= s_last;
      do @(posedge clock); while (!req_ready);
      interpolate_sample(s_real, s_imag, s_last);
      samples_sent++;
   endtask

   // Stops offering samples and waits until every expected word has come out.
   // A sample that opens a block gives no word, so a quiet stretch follows.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes the factor register (with junk in the unused upper bits) and reads it back.
   task automatic write_factor(input logic [FACTOR_REG_W-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = ({$urandom()} & ~CSR_DATA_W'((1 << FACTOR_REG_W) - 1)) | CSR_DATA_W'(value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(FACTOR_ADDR);
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      factor_reg = value;
      factor_settings++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[FACTOR_REG_W-1:0] !== value) begin
         $error("upsample_factor: expected %0d, actual %0d", value,
                prdata[FACTOR_REG_W-1:0]);
         err_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Opening a block: a lone closing sample, a stored sample and two intervals at the
   // reset factor. The sender then holds back until all has drained.
   task automatic test_block_start();
      send_sample(16'sd1234, -16'sd4321, 1'b1);
      send_sample(16'sd100, -16'sd100, 1'b0);
      send_sample(-16'sd101, 16'sd101, 1'b0);
      send_sample(16'sd7, 16'sd3, 1'b1);
      wait_until_drained();
   endtask

   // Full-scale swings at the widest factor, including a closing sample after an
   // interval, which gives the longest burst of words.
   task automatic test_full_scale();
      write_factor(FACTOR_REG_W'(MAX_FAC));
      send_sample(-16'sd32768, 16'sd32767, 1'b0);
      send_sample(16'sd32767, -16'sd32768, 1'b0);
      send_sample(-16'sd32768, 16'sd32767, 1'b0);
      send_sample(16'sd0, -16'sd1, 1'b0);
      send_sample(16'sd32767, 16'sd32767, 1'b1);
      wait_until_drained();
   endtask

   // Factor zero acts as one, one is the identity, and large values saturate.
   task automatic test_factor_limits();
      logic [FACTOR_REG_W-1:0] edge_factors[4];
      edge_factors = '{FACTOR_REG_W'(0), FACTOR_REG_W'(1),
                       FACTOR_REG_W'(MAX_FAC + 1), {FACTOR_REG_W{1'b1}}};
      foreach (edge_factors[k]) begin
         write_factor(edge_factors[k]);
         send_sample(-16'sd20000, 16'sd31000, 1'b0);
         send_sample(16'sd19999, -16'sd31001, 1'b1);
         wait_until_drained();
      end
   endtask

   // Random streams in several phases, each with its own factor. One phase runs
   // with no idling on either side.
   task automatic test_random_streams();
      int phase_factor[5];
      phase_factor = '{2, MAX_FAC, $urandom_range(0, 31), 1, $urandom_range(0, 31)};
      foreach (phase_factor[ph]) begin
         write_factor(FACTOR_REG_W'(phase_factor[ph]));
         steady_flow = (ph == 1);
         for (int n = 0; n < 20; n++) begin
            send_sample(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
         end
         wait_until_drained();
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_block_start();
      test_full_scale();
      test_factor_limits();
      test_random_streams();
      wait_until_drained();

      $display("Sent %0d samples and checked %0d words across %0d factor settings,",
               samples_sent, words_checked, factor_settings);
      $display("including factor zero, one, the maximum and values beyond it.");
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/liu_pkg.sv
sv/liu_div.sv
sv/linear_interp_upsampler.sv
dv/tb_linear_interp_upsampler.sv
